@@ src/dnhs_pkg.sv @@
// ---------------------------------------------------------------------------
// dnhs_pkg
// Shared codes, widths, reset values and types for the day/night
// hysteresis switch.
// ---------------------------------------------------------------------------
`default_nettype none

package dnhs_pkg;

   // field widths
   localparam int LEVEL_W   = 10;
   localparam int HYST_W    = 7;
   localparam int HOLD_W    = 16;
   localparam int TIME_W    = 32;
   localparam int MODE_W    = 2;
   localparam int FORCE_W   = 2;
   localparam int AVG_W     = 14;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 2;

   // signed width of the unknown-mode thresholds (x100 scale)
   localparam int THR_W = 20;

   // largest sample a 10-bit field can carry
   localparam int LEVEL_MAX = 1023;

   // mode codes
   localparam logic [MODE_W-1:0] SCENE_DAY   = 2'd0;
   localparam logic [MODE_W-1:0] SCENE_NIGHT = 2'd1;
   localparam logic [MODE_W-1:0] SCENE_UNSET = 2'd2;

   // force request codes (the fourth code means no request)
   localparam logic [FORCE_W-1:0] FORCE_NONE  = 2'd0;
   localparam logic [FORCE_W-1:0] FORCE_DAY   = 2'd1;
   localparam logic [FORCE_W-1:0] FORCE_NIGHT = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HYST = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD = 2'd3;

   // reset values
   localparam logic [LEVEL_W-1:0] LOW_RESET   = 10'd300;
   localparam logic [LEVEL_W-1:0] HIGH_RESET  = 10'd700;
   localparam logic [HYST_W-1:0]  HYST_RESET  = 7'd10;
   localparam logic [HOLD_W-1:0]  HOLD_RESET  = 16'd5;
   localparam logic [LEVEL_W-1:0] LEVEL_RESET = 10'd500;

   // configuration register set
   typedef struct packed {
      logic [LEVEL_W-1:0] low;
      logic [LEVEL_W-1:0] high;
      logic [HYST_W-1:0]  hyst;
      logic [HOLD_W-1:0]  hold;
   } csr_type;

   // per-item fields that ride along the pipeline
   typedef struct packed {
      logic [TIME_W-1:0]  now_seconds;
      logic [FORCE_W-1:0] force_request;
   } item_meta_type;

endpackage

`default_nettype wire

@@ src/dnhs_ring.sv @@
// ---------------------------------------------------------------------------
// dnhs_ring
// Sample window as a shift line of WINDOW taps with a running sum. The
// oldest sample always sits in the last tap.
// ---------------------------------------------------------------------------
`default_nettype none

module dnhs_ring #(
   parameter int WINDOW = 10
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  load,
   input  wire logic [dnhs_pkg::LEVEL_W-1:0]          sample,
   output logic [$clog2(dnhs_pkg::LEVEL_MAX*WINDOW+1)-1:0] sum
);

   localparam int SUM_W = $clog2(dnhs_pkg::LEVEL_MAX*WINDOW+1);

   logic [dnhs_pkg::LEVEL_W-1:0] taps_ff [WINDOW];
   logic [SUM_W-1:0]             sum_ff;
   logic [SUM_W-1:0]             sum_in;

   // drop the oldest sample, add the new one
   assign sum_in = sum_ff - SUM_W'(taps_ff[WINDOW-1]) + SUM_W'(sample);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW; i++) begin
            taps_ff[i] <= dnhs_pkg::LEVEL_RESET;
         end
         sum_ff <= SUM_W'(int'(dnhs_pkg::LEVEL_RESET) * WINDOW);
      end else if (load) begin
         taps_ff[0] <= sample;
         for (int i = 1; i < WINDOW; i++) begin
            taps_ff[i] <= taps_ff[i-1];
         end
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

`ifndef NO_ASSERTIONS
   // running sum never exceeds a full window of maximum samples
   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      sum_ff <= SUM_W'(dnhs_pkg::LEVEL_MAX * WINDOW))
      else $error("window sum out of range");
`endif

endmodule

`default_nettype wire

@@ src/dnhs_thresh.sv @@
// ---------------------------------------------------------------------------
// dnhs_thresh
// Unknown-mode thresholds on the x100 scale, derived from the registers:
// 100*low + gap*h and 100*high - gap*h, registered every cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module dnhs_thresh (
   input  wire logic                               clock,
   input  wire dnhs_pkg::csr_type                  csr,
   output logic signed [dnhs_pkg::THR_W-1:0]       thr_low,
   output logic signed [dnhs_pkg::THR_W-1:0]       thr_high
);

   localparam int THR_W = dnhs_pkg::THR_W;

   logic signed [dnhs_pkg::LEVEL_W:0] gap;
   logic signed [THR_W-1:0]           gap_scaled;
   logic signed [THR_W-1:0]           low_scaled;
   logic signed [THR_W-1:0]           high_scaled;
   logic signed [THR_W-1:0]           thr_low_ff;
   logic signed [THR_W-1:0]           thr_high_ff;

   // gap may be negative when software sets low above high
   assign gap         = $signed({1'b0, csr.high}) - $signed({1'b0, csr.low});
   assign gap_scaled  = THR_W'(gap) * $signed(THR_W'(csr.hyst));
   assign low_scaled  = $signed(THR_W'(int'(csr.low) * 100));
   assign high_scaled = $signed(THR_W'(int'(csr.high) * 100));

   always_ff @(posedge clock) begin
      thr_low_ff  <= low_scaled + gap_scaled;
      thr_high_ff <= high_scaled - gap_scaled;
   end

   assign thr_low  = thr_low_ff;
   assign thr_high = thr_high_ff;

endmodule

`default_nettype wire

@@ src/dnhs_mode.sv @@
// ---------------------------------------------------------------------------
// dnhs_mode
// Result stage: threshold compares, force override, hold timer, mode state
// and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module dnhs_mode #(
   parameter int WINDOW = 10
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      load,
   input  wire logic [$clog2(dnhs_pkg::LEVEL_MAX*WINDOW+1)-1:0] sum,
   input  wire logic [dnhs_pkg::AVG_W-1:0]                quot,
   input  wire dnhs_pkg::item_meta_type                   meta,
   input  wire dnhs_pkg::csr_type                         csr,
   input  wire logic signed [dnhs_pkg::THR_W-1:0]         thr_low,
   input  wire logic signed [dnhs_pkg::THR_W-1:0]         thr_high,
   output logic [dnhs_pkg::MODE_W-1:0]                    mode_now,
   output logic                                           mode_changed,
   output logic                                           change_was_forced,
   output logic                                           change_held,
   output logic [dnhs_pkg::AVG_W-1:0]                     average_level
);

   localparam int SUM_W = $clog2(dnhs_pkg::LEVEL_MAX*WINDOW+1);
   localparam int CMP_W = 20 + $clog2(WINDOW+1);
   localparam int XW    = SUM_W + 4;

   logic [dnhs_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [dnhs_pkg::TIME_W-1:0] last_ff, last_in;
   logic                        changed_ff, changed_in;
   logic                        held_ff, held_in;
   logic                        forced_ff, forced_in;
   logic [dnhs_pkg::AVG_W-1:0]  avg_ff, avg_in;

   logic [SUM_W-1:0]            low_limit;
   logic [SUM_W-1:0]            high_limit;
   logic signed [CMP_W-1:0]     sum_scaled;
   logic signed [CMP_W-1:0]     unk_low_limit;
   logic signed [CMP_W-1:0]     unk_high_limit;
   logic [dnhs_pkg::MODE_W-1:0] target;
   logic [dnhs_pkg::TIME_W-1:0] elapsed;
   logic                        too_soon;
   logic                        wanted;
   logic [XW-1:0]               quot_back;
   logic [XW-1:0]               sum_tenfold;

   // known-mode limits on the sum scale
   assign low_limit  = SUM_W'(int'(csr.low) * WINDOW);
   assign high_limit = SUM_W'(int'(csr.high) * WINDOW);

   // unknown-mode limits on the x100 scale
   assign sum_scaled     = $signed(CMP_W'(int'(sum) * 100));
   assign unk_low_limit  = CMP_W'(int'(thr_low) * WINDOW);
   assign unk_high_limit = CMP_W'(int'(thr_high) * WINDOW);

   // target mode, then force override
   always_comb begin
      forced_in = 1'b0;
      case (mode_ff)
         dnhs_pkg::SCENE_DAY: begin
            target = (sum < low_limit) ? dnhs_pkg::SCENE_NIGHT : dnhs_pkg::SCENE_DAY;
         end
         dnhs_pkg::SCENE_NIGHT: begin
            target = (sum > high_limit) ? dnhs_pkg::SCENE_DAY : dnhs_pkg::SCENE_NIGHT;
         end
         default: begin
            if (sum_scaled < unk_low_limit) begin
               target = dnhs_pkg::SCENE_NIGHT;
            end else if (sum_scaled > unk_high_limit) begin
               target = dnhs_pkg::SCENE_DAY;
            end else begin
               target = mode_ff;
            end
         end
      endcase
      case (meta.force_request)
         dnhs_pkg::FORCE_DAY: begin
            target    = dnhs_pkg::SCENE_DAY;
            forced_in = 1'b1;
         end
         dnhs_pkg::FORCE_NIGHT: begin
            target    = dnhs_pkg::SCENE_NIGHT;
            forced_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // hold timer, no hold out of unknown mode
   assign elapsed  = meta.now_seconds - last_ff;
   assign too_soon = elapsed < dnhs_pkg::TIME_W'(csr.hold);
   assign wanted   = (target != mode_ff) && (target != dnhs_pkg::SCENE_UNSET);
   assign held_in    = wanted && (mode_ff != dnhs_pkg::SCENE_UNSET) && too_soon;
   assign changed_in = wanted && !held_in;
   assign mode_in    = changed_in ? target : mode_ff;
   assign last_in    = changed_in ? meta.now_seconds : last_ff;

   // reciprocal estimate is exact or one high; check it against the sum
   assign quot_back   = XW'(quot) * XW'(WINDOW);
   assign sum_tenfold = XW'(sum) * XW'(10);
   assign avg_in      = (quot_back > sum_tenfold) ? quot - dnhs_pkg::AVG_W'(1) : quot;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= dnhs_pkg::SCENE_UNSET;
         last_ff    <= '0;
         changed_ff <= 1'b0;
         held_ff    <= 1'b0;
      end else if (load) begin
         mode_ff    <= mode_in;
         last_ff    <= last_in;
         changed_ff <= changed_in;
         held_ff    <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         forced_ff <= forced_in;
         avg_ff    <= avg_in;
      end
   end

   assign mode_now          = mode_ff;
   assign mode_changed      = changed_ff;
   assign change_was_forced = forced_ff;
   assign change_held       = held_ff;
   assign average_level     = avg_ff;

`ifndef NO_ASSERTIONS
   // a transition and a hold never come from the same sample
   a_change_xor_hold: assert property (@(posedge clock) disable iff (reset)
      !(changed_ff && held_ff))
      else $error("transition and hold flagged together");

   // hold applies only once a mode is known
   a_hold_known: assert property (@(posedge clock) disable iff (reset)
      held_ff |-> (mode_ff != dnhs_pkg::SCENE_UNSET))
      else $error("hold reported in unknown mode");

   // a transition stamps the sample time
   a_change_stamp: assert property (@(posedge clock) disable iff (reset)
      (load && changed_in) |=> (last_ff == $past(meta.now_seconds)))
      else $error("last change time not updated");
`endif

endmodule

`default_nettype wire

@@ src/day_night_hysteresis_switch_core.sv @@
// ---------------------------------------------------------------------------
// day_night_hysteresis_switch_core
// Moving-average brightness window with hysteresis day/night selection.
// ---------------------------------------------------------------------------
// One sample is taken per cycle while req_stall is low; the window updates at
// the transfer edge, then the reciprocal average and the compare/mode stage
// are registered in turn, which puts the result on the outputs, and
// transfers keep flowing back to back as long as results are taken. The
// window is a shift line of WINDOW taps with a running sum, so no clearing
// pass is needed after reset. The mode and last-change time close their loop
// inside the result stage, which is why one sample can follow another in
// consecutive cycles. Registers may be written whenever no sample is in
// flight.
`default_nettype none

module day_night_hysteresis_switch_core #(
   parameter int WINDOW = 10
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // sample input
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [dnhs_pkg::LEVEL_W-1:0]        req_sample_level,
   input  wire logic [dnhs_pkg::TIME_W-1:0]         req_now_seconds,
   input  wire logic [dnhs_pkg::FORCE_W-1:0]        req_force_request,
   // result output
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [dnhs_pkg::MODE_W-1:0]              rsp_mode_now,
   output logic                                     rsp_mode_changed,
   output logic                                     rsp_change_was_forced,
   output logic                                     rsp_change_held,
   output logic [dnhs_pkg::AVG_W-1:0]               rsp_average_level,
   // register writes
   input  wire logic                                csr_write,
   input  wire logic [dnhs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [dnhs_pkg::CSR_W-1:0]          csr_data
);

   localparam int SUM_W = $clog2(dnhs_pkg::LEVEL_MAX*WINDOW+1);
   localparam int RCP_W = SUM_W + 4;
   localparam int PRD_W = SUM_W + RCP_W;
   // ceil(10 * 2^SUM_W / WINDOW)
   localparam longint RECIP_L =
      ((longint'(10) << SUM_W) + longint'(WINDOW) - 1) / longint'(WINDOW);
   localparam logic [RCP_W-1:0] RECIP = RCP_W'(RECIP_L);

   dnhs_pkg::csr_type       csr_ff, csr_in;
   dnhs_pkg::item_meta_type meta1_ff, meta2_ff;

   logic                    v1_ff, v1_in;
   logic                    v2_ff, v2_in;
   logic                    v3_ff, v3_in;
   logic                    load1, load2, load3;
   logic                    accept;

   logic [SUM_W-1:0]            win_sum;
   logic [PRD_W-1:0]            avg_prod;
   logic [SUM_W-1:0]            sum2_ff;
   logic [dnhs_pkg::AVG_W-1:0]  quot2_ff;
   logic signed [dnhs_pkg::THR_W-1:0] thr_low;
   logic signed [dnhs_pkg::THR_W-1:0] thr_high;

   // register writes
   always_comb begin
      csr_in = csr_ff;
      if (csr_write) begin
         case (csr_index)
            dnhs_pkg::CSR_LOW:  csr_in.low  = csr_data[dnhs_pkg::LEVEL_W-1:0];
            dnhs_pkg::CSR_HIGH: csr_in.high = csr_data[dnhs_pkg::LEVEL_W-1:0];
            dnhs_pkg::CSR_HYST: csr_in.hyst = csr_data[dnhs_pkg::HYST_W-1:0];
            dnhs_pkg::CSR_HOLD: csr_in.hold = csr_data[dnhs_pkg::HOLD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.low  <= dnhs_pkg::LOW_RESET;
         csr_ff.high <= dnhs_pkg::HIGH_RESET;
         csr_ff.hyst <= dnhs_pkg::HYST_RESET;
         csr_ff.hold <= dnhs_pkg::HOLD_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // pipeline flow: a stage loads when empty or when it drains forward
   assign load3  = !v3_ff || !rsp_stall;
   assign load2  = !v2_ff || load3;
   assign load1  = !v1_ff || load2;
   assign accept = req_valid && load1;

   assign v1_in = load1 ? accept : v1_ff;
   assign v2_in = load2 ? v1_ff : v2_ff;
   assign v3_in = load3 ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // stage 1: window and running sum
   dnhs_ring #(
      .WINDOW (WINDOW)
   ) u_ring (
      .clock  (clock),
      .reset  (reset),
      .load   (accept),
      .sample (req_sample_level),
      .sum    (win_sum)
   );

   always_ff @(posedge clock) begin
      if (accept) begin
         meta1_ff.now_seconds   <= req_now_seconds;
         meta1_ff.force_request <= req_force_request;
      end
   end

   // stage 2: average estimate by reciprocal multiply
   assign avg_prod = PRD_W'(win_sum) * PRD_W'(RECIP);

   always_ff @(posedge clock) begin
      if (load2 && v1_ff) begin
         sum2_ff  <= win_sum;
         quot2_ff <= avg_prod[SUM_W +: dnhs_pkg::AVG_W];
         meta2_ff <= meta1_ff;
      end
   end

   dnhs_thresh u_thresh (
      .clock    (clock),
      .csr      (csr_ff),
      .thr_low  (thr_low),
      .thr_high (thr_high)
   );

   // stage 3: decision and result register
   dnhs_mode #(
      .WINDOW (WINDOW)
   ) u_mode (
      .clock             (clock),
      .reset             (reset),
      .load              (load3 && v2_ff),
      .sum               (sum2_ff),
      .quot              (quot2_ff),
      .meta              (meta2_ff),
      .csr               (csr_ff),
      .thr_low           (thr_low),
      .thr_high          (thr_high),
      .mode_now          (rsp_mode_now),
      .mode_changed      (rsp_mode_changed),
      .change_was_forced (rsp_change_was_forced),
      .change_held       (rsp_change_held),
      .average_level     (rsp_average_level)
   );

   assign req_stall = !load1;
   assign rsp_valid = v3_ff;

`ifndef NO_ASSERTIONS
   // with every stage full and the output stalled, no transfer is taken
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && v2_ff && v3_ff && rsp_stall) |-> req_stall)
      else $error("input taken while pipeline is full");

   // a transfer into stage 1 always leaves it occupied
   a_accept_fill: assert property (@(posedge clock) disable iff (reset)
      accept |=> v1_ff)
      else $error("accepted sample lost from stage 1");
`endif

endmodule

`default_nettype wire

@@ test/dnhs_result_checker.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// dnhs_result_checker
// Watches the sample, result and register ports of the day/night switch,
// keeps its own copy of the window, mode and registers, predicts every
// result and compares it field by field with what the block hands out.
// ---------------------------------------------------------------------------
module dnhs_result_checker #(
   parameter int WINDOW = 10
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic                           req_stall,
   input  wire logic [dnhs_pkg::LEVEL_W-1:0]   req_sample_level,
   input  wire logic [dnhs_pkg::TIME_W-1:0]    req_now_seconds,
   input  wire logic [dnhs_pkg::FORCE_W-1:0]   req_force_request,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   input  wire logic [dnhs_pkg::MODE_W-1:0]    rsp_mode_now,
   input  wire logic                           rsp_mode_changed,
   input  wire logic                           rsp_change_was_forced,
   input  wire logic                           rsp_change_held,
   input  wire logic [dnhs_pkg::AVG_W-1:0]     rsp_average_level,
   input  wire logic                           csr_write,
   input  wire logic [dnhs_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [dnhs_pkg::CSR_W-1:0]     csr_data,
   output int                                  fail_count,
   output int                                  pending_count,
   output int                                  checked_count,
   output int                                  change_count,
   output int                                  held_count
);

   localparam int REPORT_MAX = 10;

   typedef struct packed {
      logic [dnhs_pkg::MODE_W-1:0] mode_now;
      logic                        changed;
      logic                        forced;
      logic                        held;
      logic [dnhs_pkg::AVG_W-1:0]  average;
   } switch_result_type;

   // results still owed by the block, oldest first
   switch_result_type mode_expect_q[$];

   // register copies
   logic [dnhs_pkg::LEVEL_W-1:0] cfg_low;
   logic [dnhs_pkg::LEVEL_W-1:0] cfg_high;
   logic [dnhs_pkg::HYST_W-1:0]  cfg_hyst;
   logic [dnhs_pkg::HOLD_W-1:0]  cfg_hold;

   // window and mode state
   logic [dnhs_pkg::LEVEL_W-1:0] win_ring [WINDOW];
   int                           win_slot;
   int                           win_sum;
   logic [dnhs_pkg::MODE_W-1:0]  mode_state;
   logic [dnhs_pkg::TIME_W-1:0]  last_change;

   task automatic restore_defaults();
      int k;
      cfg_low  = dnhs_pkg::LOW_RESET;
      cfg_high = dnhs_pkg::HIGH_RESET;
      cfg_hyst = dnhs_pkg::HYST_RESET;
      cfg_hold = dnhs_pkg::HOLD_RESET;
      for (k = 0; k < WINDOW; k++) win_ring[k] = dnhs_pkg::LEVEL_RESET;
      win_slot    = 0;
      win_sum     = WINDOW * int'(dnhs_pkg::LEVEL_RESET);
      mode_state  = dnhs_pkg::SCENE_UNSET;
      last_change = '0;
   endtask

   // one sample: window update, threshold compare, force, hold time
   task automatic predict_mode(input logic [dnhs_pkg::LEVEL_W-1:0] level,
                               input logic [dnhs_pkg::TIME_W-1:0]  now,
                               input logic [dnhs_pkg::FORCE_W-1:0] frc);
      switch_result_type           r;
      logic [dnhs_pkg::MODE_W-1:0] goal;
      logic [dnhs_pkg::TIME_W-1:0] since;
      int                          lo, hi, gap, avg;
      r = '0;
      win_sum = win_sum - int'(win_ring[win_slot]) + int'(level);
      win_ring[win_slot] = level;
      win_slot = (win_slot == WINDOW - 1) ? 0 : win_slot + 1;
      lo = int'(cfg_low);
      hi = int'(cfg_high);

      if (mode_state == dnhs_pkg::SCENE_DAY) begin
         goal = (win_sum < lo * WINDOW) ? dnhs_pkg::SCENE_NIGHT : dnhs_pkg::SCENE_DAY;
      end else if (mode_state == dnhs_pkg::SCENE_NIGHT) begin
         goal = (win_sum > hi * WINDOW) ? dnhs_pkg::SCENE_DAY : dnhs_pkg::SCENE_NIGHT;
      end else begin
         // unknown: thresholds pulled inward, compared at x100 scale
         gap = (hi - lo) * int'(cfg_hyst);
         if (100 * win_sum < WINDOW * (100 * lo + gap))
            goal = dnhs_pkg::SCENE_NIGHT;
         else if (100 * win_sum > WINDOW * (100 * hi - gap))
            goal = dnhs_pkg::SCENE_DAY;
         else
            goal = mode_state;
      end

      // force overrides; code three counts as no request
      if (frc == dnhs_pkg::FORCE_DAY) begin
         goal     = dnhs_pkg::SCENE_DAY;
         r.forced = 1'b1;
      end else if (frc == dnhs_pkg::FORCE_NIGHT) begin
         goal     = dnhs_pkg::SCENE_NIGHT;
         r.forced = 1'b1;
      end

      if (goal != mode_state && goal != dnhs_pkg::SCENE_UNSET) begin
         since = now - last_change;
         if (mode_state != dnhs_pkg::SCENE_UNSET && since < cfg_hold) begin
            r.held = 1'b1;
            held_count++;
         end else begin
            mode_state  = goal;
            last_change = now;
            r.changed   = 1'b1;
            change_count++;
         end
      end

      avg        = win_sum * 10 / WINDOW;
      r.mode_now = mode_state;
      r.average  = avg[dnhs_pkg::AVG_W-1:0];
      mode_expect_q.push_back(r);
   endtask

   always @(posedge clock) begin : watch
      switch_result_type got;
      switch_result_type want;
      if (reset) begin
         restore_defaults();
         mode_expect_q.delete();
      end else begin
         // register writes
         if (csr_write === 1'b1) begin
            case (csr_index)
               dnhs_pkg::CSR_LOW:  cfg_low  = csr_data[dnhs_pkg::LEVEL_W-1:0];
               dnhs_pkg::CSR_HIGH: cfg_high = csr_data[dnhs_pkg::LEVEL_W-1:0];
               dnhs_pkg::CSR_HYST: cfg_hyst = csr_data[dnhs_pkg::HYST_W-1:0];
               dnhs_pkg::CSR_HOLD: cfg_hold = csr_data[dnhs_pkg::HOLD_W-1:0];
               default: ;
            endcase
         end

         // result transfer
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            got = {rsp_mode_now, rsp_mode_changed, rsp_change_was_forced,
                   rsp_change_held, rsp_average_level};
            if (mode_expect_q.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_MAX)
                  $display("%0t: result with nothing expected: mode %0d avg %0d",
                           $time, got.mode_now, got.average);
            end else begin
               want = mode_expect_q.pop_front();
               checked_count++;
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= REPORT_MAX) begin
                     $display("%0t: result %0d: want mode %0d chg %0b frc %0b held %0b avg %0d",
                              $time, checked_count, want.mode_now, want.changed,
                              want.forced, want.held, want.average);
                     $display("   got mode %0d chg %0b frc %0b held %0b avg %0d",
                              got.mode_now, got.changed, got.forced, got.held,
                              got.average);
                  end
               end
            end
         end

         // sample transfer
         if (req_valid === 1'b1 && req_stall === 1'b0)
            predict_mode(req_sample_level, req_now_seconds, req_force_request);
      end
      pending_count = mode_expect_q.size();
   end

endmodule

@@ test/day_night_hysteresis_switch_core_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// day_night_hysteresis_switch_core_tb
// Drives brightness samples with timestamps and force requests into the
// day/night switch under several threshold, hysteresis and hold settings,
// with random gaps on both channels; the checker beside the block predicts
// and compares every result, and this module gives the verdict.
// ---------------------------------------------------------------------------
module day_night_hysteresis_switch_core_tb;

   localparam int LATENCY       = 3;
   localparam int SETTLE_CYCLES = LATENCY + 3;
   localparam int PHASE_COUNT   = 9;
   localparam int PHASE_ITEMS   = 216;
   localparam int LEVEL_W       = dnhs_pkg::LEVEL_W;
   localparam int HYST_W        = dnhs_pkg::HYST_W;
   localparam int HOLD_W        = dnhs_pkg::HOLD_W;
   localparam int CSR_W         = dnhs_pkg::CSR_W;
   localparam int LEVEL_MAX     = dnhs_pkg::LEVEL_MAX;
   // fourth force code, taken as no request
   localparam logic [dnhs_pkg::FORCE_W-1:0] FORCE_RESERVED = 2'd3;

   logic                               clock     = 1'b0;
   logic                               reset     = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic [LEVEL_W-1:0]                 req_sample_level  = '0;
   logic [dnhs_pkg::TIME_W-1:0]        req_now_seconds   = '0;
   logic [dnhs_pkg::FORCE_W-1:0]       req_force_request = dnhs_pkg::FORCE_NONE;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic [dnhs_pkg::MODE_W-1:0]        rsp_mode_now;
   logic                               rsp_mode_changed;
   logic                               rsp_change_was_forced;
   logic                               rsp_change_held;
   logic [dnhs_pkg::AVG_W-1:0]         rsp_average_level;
   logic                               csr_write = 1'b0;
   logic [dnhs_pkg::CSR_IDX_W-1:0]     csr_index = dnhs_pkg::CSR_LOW;
   logic [CSR_W-1:0]                   csr_data  = '0;

   int fail_count, pending_count, checked_count, change_count, held_count;
   int send_idle_pct, recv_idle_pct;

   // settings of the current phase
   logic [LEVEL_W-1:0]          set_low  = dnhs_pkg::LOW_RESET;
   logic [LEVEL_W-1:0]          set_high = dnhs_pkg::HIGH_RESET;
   logic [HYST_W-1:0]           set_hyst = dnhs_pkg::HYST_RESET;
   logic [HOLD_W-1:0]           set_hold = dnhs_pkg::HOLD_RESET;
   logic [dnhs_pkg::TIME_W-1:0] clock_now = '0;

   day_night_hysteresis_switch_core i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_sample_level      (req_sample_level),
      .req_now_seconds       (req_now_seconds),
      .req_force_request     (req_force_request),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_mode_now          (rsp_mode_now),
      .rsp_mode_changed      (rsp_mode_changed),
      .rsp_change_was_forced (rsp_change_was_forced),
      .rsp_change_held       (rsp_change_held),
      .rsp_average_level     (rsp_average_level),
      .csr_write             (csr_write),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   dnhs_result_checker i_checker (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_sample_level      (req_sample_level),
      .req_now_seconds       (req_now_seconds),
      .req_force_request     (req_force_request),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_mode_now          (rsp_mode_now),
      .rsp_mode_changed      (rsp_mode_changed),
      .rsp_change_was_forced (rsp_change_was_forced),
      .rsp_change_held       (rsp_change_held),
      .rsp_average_level     (rsp_average_level),
      .csr_write             (csr_write),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .fail_count            (fail_count),
      .pending_count         (pending_count),
      .checked_count         (checked_count),
      .change_count          (change_count),
      .held_count            (held_count)
   );

   always #4 clock = ~clock;

   // receiver stalls at random
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   // one sample transfer, after a random gap; payload held while stalled
   task automatic send_sample(input logic [LEVEL_W-1:0]                level,
                              input logic [dnhs_pkg::TIME_W-1:0]  now,
                              input logic [dnhs_pkg::FORCE_W-1:0] frc);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_sample_level  <= level;
      req_now_seconds   <= now;
      req_force_request <= frc;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // wait for every owed result, then let the pipeline settle
   task automatic drain_results();
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // all four registers; bits above each register's width carry noise
   task automatic write_regs();
      logic [CSR_W-1:0] junk;
      junk = CSR_W'($urandom_range(0, 16'hFFFF));
      csr_write <= 1'b1;
      csr_index <= dnhs_pkg::CSR_LOW;
      csr_data  <= {junk[CSR_W-1:LEVEL_W], set_low};
      @(posedge clock);
      junk = CSR_W'($urandom_range(0, 16'hFFFF));
      csr_index <= dnhs_pkg::CSR_HIGH;
      csr_data  <= {junk[CSR_W-1:LEVEL_W], set_high};
      @(posedge clock);
      junk = CSR_W'($urandom_range(0, 16'hFFFF));
      csr_index <= dnhs_pkg::CSR_HYST;
      csr_data  <= {junk[CSR_W-1:HYST_W], set_hyst};
      @(posedge clock);
      csr_index <= dnhs_pkg::CSR_HOLD;
      csr_data  <= set_hold;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic pick_setting(input int phase);
      case (phase)
         0: begin set_low = dnhs_pkg::LOW_RESET; set_high = dnhs_pkg::HIGH_RESET;
                  set_hyst = dnhs_pkg::HYST_RESET; set_hold = dnhs_pkg::HOLD_RESET; end
         1: begin set_low = 10'd0;    set_high = 10'd1023; set_hyst = 7'd0;
                  set_hold = 16'd0; end
         // low above high, widest shift, longest hold
         2: begin set_low = 10'd1023; set_high = 10'd0;    set_hyst = 7'd127;
                  set_hold = 16'hFFFF; end
         3: begin set_low = 10'd400;  set_high = 10'd600;  set_hyst = 7'd50;
                  set_hold = 16'd3; end
         4: begin set_low = 10'd500;  set_high = 10'd500;  set_hyst = 7'd100;
                  set_hold = 16'd1; end
         5: begin set_low = 10'd0;    set_high = 10'd0;    set_hyst = 7'd127;
                  set_hold = 16'd0; end
         6: begin set_low = 10'd1023; set_high = 10'd1023; set_hyst = 7'd0;
                  set_hold = 16'd10; end
         7: begin set_low = 10'd200;  set_high = 10'd900;  set_hyst = 7'd25;
                  set_hold = 16'hFFFF; end
         default: begin
            set_low  = LEVEL_W'($urandom_range(0, LEVEL_MAX));
            set_high = LEVEL_W'($urandom_range(0, LEVEL_MAX));
            set_hyst = HYST_W'($urandom_range(0, 127));
            set_hold = HOLD_W'($urandom_range(0, 20));
         end
      endcase
   endtask

   // edges of the fields and the named corner cases, under reset settings
   task automatic run_directed();
      int k;
      send_sample(10'd500, 32'd0, dnhs_pkg::FORCE_NONE);
      send_sample(10'd1023, 32'd1, FORCE_RESERVED);       // code three: no request
      for (k = 2; k < 7; k++)                             // climbs into day
         send_sample(10'd1023, k, dnhs_pkg::FORCE_NONE);
      send_sample(10'd1000, 32'd7, dnhs_pkg::FORCE_DAY);  // force to current mode
      send_sample(10'd0, 32'd8, dnhs_pkg::FORCE_NIGHT);   // blocked by hold
      for (k = 9; k < 17; k++)                            // falls toward night
         send_sample(10'd0, k, dnhs_pkg::FORCE_NONE);
      send_sample(10'd0, 32'hFFFF_FFF0, dnhs_pkg::FORCE_DAY);
      send_sample(10'd1023, 32'hFFFF_FFFF, dnhs_pkg::FORCE_NIGHT);
      send_sample(10'd1023, 32'd2, dnhs_pkg::FORCE_DAY);  // wrapped gap under hold
      send_sample(10'd1023, 32'd4, dnhs_pkg::FORCE_DAY);  // wrapped gap at hold
      send_sample(10'd0, 32'd4, dnhs_pkg::FORCE_NIGHT);
      clock_now = 32'd4;
   endtask

   // runs of samples around the thresholds with noise, time mostly advancing
   task automatic run_scene(input int n_items);
      int                           base, lvl, run_left, sel, step_cap;
      logic [dnhs_pkg::FORCE_W-1:0] frc;
      run_left = 0;
      base     = int'(dnhs_pkg::LEVEL_RESET);
      step_cap = (set_hold > 15) ? 30 : 2 * int'(set_hold) + 1;
      repeat (n_items) begin
         if (run_left == 0) begin
            run_left = $urandom_range(4, 24);
            sel      = $urandom_range(0, 9);
            if (sel < 4)
               base = int'(set_low) + int'($urandom_range(0, 120)) - 60;
            else if (sel < 8)
               base = int'(set_high) + int'($urandom_range(0, 120)) - 60;
            else
               base = $urandom_range(0, LEVEL_MAX);
         end
         run_left--;

         if ($urandom_range(0, 99) < 5)
            lvl = $urandom_range(0, LEVEL_MAX);
         else
            lvl = base + int'($urandom_range(0, 60)) - 30;
         if (lvl < 0) lvl = 0;
         else if (lvl > LEVEL_MAX) lvl = LEVEL_MAX;

         if ($urandom_range(0, 99) < 4)
            clock_now = $urandom();
         else
            clock_now = clock_now + $urandom_range(0, step_cap);

         sel = $urandom_range(0, 99);
         if (sel < 5)       frc = dnhs_pkg::FORCE_DAY;
         else if (sel < 10) frc = dnhs_pkg::FORCE_NIGHT;
         else if (sel < 13) frc = FORCE_RESERVED;
         else               frc = dnhs_pkg::FORCE_NONE;

         send_sample(lvl[LEVEL_W-1:0], clock_now, frc);
      end
   endtask

   initial begin : stimulus
      int phase;
      send_idle_pct = 37;
      recv_idle_pct = 58;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      run_directed();

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         // sender holds off until every result is back, then registers change
         req_valid <= 1'b0;
         drain_results();
         pick_setting(phase);
         write_regs();
         if (phase == 3) begin
            send_idle_pct = 58;
            recv_idle_pct = 37;
         end else if (phase == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         run_scene(PHASE_ITEMS);
      end
      req_valid <= 1'b0;
      drain_results();

      $display("Checked %0d results over %0d register settings and three stall mixes;",
               checked_count, PHASE_COUNT + 1);
      $display("the predicted mode made %0d transitions and %0d held changes.",
               change_count, held_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("** day_night_hysteresis_switch_core: PASSED **");
      end else begin
         $display("%0d failures", fail_count);
         $display("** day_night_hysteresis_switch_core: FAILED **");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("run timed out");
      $display("** day_night_hysteresis_switch_core: FAILED **");
      $finish;
   end

endmodule
